/* rtl/source_text_tokenizer_defines.svh */
// Assertion macros used by the tokenizer checker stt_checker.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define STT_ASSERT_IMPL(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define STT_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/stt_pkg.sv */
package stt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int DEPTH_BITS_DEF  = 8;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_RESULTS     = 3;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [4:0] K_OP      = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_NUM     = 5'd2;
    localparam logic [4:0] K_STR     = 5'd3;
    localparam logic [4:0] K_DOT     = 5'd4;
    localparam logic [4:0] K_COLON   = 5'd5;
    localparam logic [4:0] K_SEMI    = 5'd6;
    localparam logic [4:0] K_COMMA   = 5'd7;
    localparam logic [4:0] K_EQ      = 5'd8;
    localparam logic [4:0] K_LPAREN  = 5'd9;
    localparam logic [4:0] K_RPAREN  = 5'd10;
    localparam logic [4:0] K_LBRACE  = 5'd11;
    localparam logic [4:0] K_RBRACE  = 5'd12;
    localparam logic [4:0] K_LBRACK  = 5'd13;
    localparam logic [4:0] K_RBRACK  = 5'd14;
    localparam logic [4:0] K_COMMENT = 5'd15;
    localparam logic [4:0] K_SPACE   = 5'd16;
    localparam logic [4:0] K_NONE    = 5'd17;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_ILLEGAL = 3'd1;
    localparam logic [2:0] E_CONTROL = 3'd2;
    localparam logic [2:0] E_NUMBER  = 3'd3;
    localparam logic [2:0] E_STRING  = 3'd4;
    localparam logic [2:0] E_COMMENT = 3'd5;

    localparam logic CFG_EMIT_WS = 1'b0;
    localparam logic CFG_EMIT_CM = 1'b1;

    typedef enum logic [9:0] {
        M_IDLE       = 10'b00_0000_0001,
        M_IDENT      = 10'b00_0000_0010,
        M_NUMFIRST   = 10'b00_0000_0100,
        M_NUMBODY    = 10'b00_0000_1000,
        M_STRING     = 10'b00_0001_0000,
        M_LINECMT    = 10'b00_0010_0000,
        M_BLOCK      = 10'b00_0100_0000,
        M_STAR       = 10'b00_1000_0000,
        M_STAR_SLASH = 10'b01_0000_0000,
        M_SPACE      = 10'b10_0000_0000
    } t_mode;

    typedef enum logic [1:0] {
        B_DEC = 2'd0,
        B_HEX = 2'd1,
        B_OCT = 2'd2,
        B_BIN = 2'd3
    } t_base;

    typedef struct packed {
        t_mode       mode;
        t_base       base;
        logic        digit_seen;
        logic        slash_pending;
        logic [7:0]  prev_byte;
        logic [23:0] line_count;
        logic [23:0] begin_line;
    } t_scan;

    typedef struct packed {
        logic [2:0]  err;
        logic [23:0] line;
        logic [7:0]  length;
        logic [23:0] offset;
        logic [4:0]  kind;
    } t_result;

    typedef struct packed {
        logic    last;
        t_result res;
    } t_entry;

    function automatic t_scan scan_reset();
        t_scan s;
        s.mode          = M_IDLE;
        s.base          = B_DEC;
        s.digit_seen    = 1'b0;
        s.slash_pending = 1'b0;
        s.prev_byte     = 8'd0;
        s.line_count    = 24'd1;
        s.begin_line    = 24'd1;
        return s;
    endfunction

endpackage

/* rtl/stt_step.sv */
module stt_step #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = stt_pkg::DEPTH_BITS_DEF
) (
    input  stt_pkg::t_scan          i_scan,
    input  logic [OFFSET_BITS-1:0]  i_tstart,
    input  logic [OFFSET_BITS-1:0]  i_pos,
    input  logic [DEPTH_BITS-1:0]   i_depth,
    input  logic [7:0]              i_byte,
    input  logic                    i_eot,
    input  logic                    i_emit_ws,
    input  logic                    i_emit_cm,
    output stt_pkg::t_scan          o_scan,
    output logic [OFFSET_BITS-1:0]  o_tstart,
    output logic [OFFSET_BITS-1:0]  o_pos,
    output logic [DEPTH_BITS-1:0]   o_depth,
    output stt_pkg::t_entry         o_ent [stt_pkg::MAX_RESULTS],
    output logic [1:0]              o_count
);

    localparam logic [DEPTH_BITS-1:0] DMAX = '1;

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == 8'h5F;
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic base_digit(logic [7:0] b, stt_pkg::t_base base);
        logic r;
        unique case (base)
            stt_pkg::B_HEX: r = is_digit(b) || (b >= 8'h61 && b <= 8'h66)
                                || (b >= 8'h41 && b <= 8'h46);
            stt_pkg::B_OCT: r = b >= 8'h30 && b <= 8'h37;
            stt_pkg::B_BIN: r = b == 8'h30 || b == 8'h31;
            default:        r = is_digit(b);
        endcase
        return r;
    endfunction

    function automatic logic [5:0] punct(logic [7:0] b);
        logic [5:0] r;
        r = {1'b1, stt_pkg::K_OP};
        unique case (b)
            8'h2A, 8'h2B, 8'h2D: r = {1'b1, stt_pkg::K_OP};
            8'h2E: r = {1'b1, stt_pkg::K_DOT};
            8'h3A: r = {1'b1, stt_pkg::K_COLON};
            8'h3B: r = {1'b1, stt_pkg::K_SEMI};
            8'h2C: r = {1'b1, stt_pkg::K_COMMA};
            8'h3D: r = {1'b1, stt_pkg::K_EQ};
            8'h28: r = {1'b1, stt_pkg::K_LPAREN};
            8'h29: r = {1'b1, stt_pkg::K_RPAREN};
            8'h7B: r = {1'b1, stt_pkg::K_LBRACE};
            8'h7D: r = {1'b1, stt_pkg::K_RBRACE};
            8'h5B: r = {1'b1, stt_pkg::K_LBRACK};
            8'h5D: r = {1'b1, stt_pkg::K_RBRACK};
            default: r = {1'b0, stt_pkg::K_OP};
        endcase
        return r;
    endfunction

    function automatic logic [23:0] off24(logic [OFFSET_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[23:0];
    endfunction

    function automatic stt_pkg::t_result mk(logic [4:0] kind, logic [OFFSET_BITS-1:0] off,
                                            logic [7:0] len, logic [23:0] line,
                                            logic [2:0] err);
        stt_pkg::t_result r;
        r.kind   = kind;
        r.offset = off24(off);
        r.length = len;
        r.line   = line;
        r.err    = err;
        return r;
    endfunction

    function automatic logic [7:0] span(logic [OFFSET_BITS-1:0] from,
                                        logic [OFFSET_BITS-1:0] upto);
        return upto[7:0] - from[7:0];
    endfunction

    function automatic logic kept(logic [4:0] kind, logic ews, logic ecm);
        return !((kind == stt_pkg::K_SPACE && !ews) || (kind == stt_pkg::K_COMMENT && !ecm));
    endfunction

    stt_pkg::t_result       slot [stt_pkg::MAX_RESULTS];
    logic [2:0]             slot_v;

    always_comb begin
        stt_pkg::t_scan         sc;
        logic [OFFSET_BITS-1:0] ts;
        logic [OFFSET_BITS-1:0] p;
        logic [OFFSET_BITS-1:0] p1;
        logic [DEPTH_BITS-1:0]  dp;
        logic [7:0]             b;
        logic                   do_idle;
        logic [5:0]             pk;
        logic [7:0]             len;

        sc      = i_scan;
        ts      = i_tstart;
        p       = i_pos;
        p1      = p + 1'b1;
        dp      = i_depth;
        b       = i_byte;
        do_idle = 1'b0;
        pk      = punct(b);
        slot_v  = 3'b000;
        for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
            slot[i] = '0;
        end

        // First result: the token that this byte closes.
        unique case (sc.mode)
            stt_pkg::M_IDENT: begin
                if (!is_alpha(b) && !is_digit(b)) begin
                    slot[0]   = mk(stt_pkg::K_IDENT, ts, span(ts, p), sc.begin_line,
                                   stt_pkg::E_NONE);
                    slot_v[0] = 1'b1;
                    do_idle   = 1'b1;
                end
            end
            stt_pkg::M_NUMFIRST, stt_pkg::M_NUMBODY: begin
                logic body;
                body = 1'b1;
                if (sc.mode == stt_pkg::M_NUMFIRST) begin
                    sc.mode       = stt_pkg::M_NUMBODY;
                    sc.digit_seen = 1'b0;
                    body          = 1'b0;
                    if (sc.prev_byte == stt_pkg::CH_ZERO
                        && (b == stt_pkg::CH_X || b == stt_pkg::CH_O || b == stt_pkg::CH_B))
                    begin
                        sc.base = (b == stt_pkg::CH_X) ? stt_pkg::B_HEX :
                                  (b == stt_pkg::CH_O) ? stt_pkg::B_OCT : stt_pkg::B_BIN;
                    end else if (b == stt_pkg::CH_DOT) begin
                        sc.base = stt_pkg::B_DEC;
                    end else begin
                        sc.base       = stt_pkg::B_DEC;
                        sc.digit_seen = 1'b1;
                        body          = 1'b1;
                    end
                end
                if (body) begin
                    if (base_digit(b, sc.base)) begin
                        sc.digit_seen = 1'b1;
                    end else begin
                        if (sc.digit_seen) begin
                            slot[0] = mk(stt_pkg::K_NUM, ts, span(ts, p), sc.begin_line,
                                         stt_pkg::E_NONE);
                        end else begin
                            slot[0] = mk(stt_pkg::K_NONE, ts, 8'd0, sc.begin_line,
                                         stt_pkg::E_NUMBER);
                        end
                        slot_v[0] = 1'b1;
                        do_idle   = 1'b1;
                    end
                end
            end
            stt_pkg::M_STRING: begin
                if (b == stt_pkg::CH_QUOTE && sc.prev_byte != stt_pkg::CH_BSLASH) begin
                    slot[0]   = mk(stt_pkg::K_STR, ts, span(ts, p), sc.begin_line,
                                   stt_pkg::E_NONE);
                    slot_v[0] = 1'b1;
                    sc.mode   = stt_pkg::M_IDLE;
                end else if (b == stt_pkg::CH_NL && sc.line_count != stt_pkg::LINE_MAX) begin
                    sc.line_count = sc.line_count + 1'b1;
                end
            end
            stt_pkg::M_LINECMT: begin
                if (b == stt_pkg::CH_NL) begin
                    slot[0]   = mk(stt_pkg::K_COMMENT, ts, span(ts, p), sc.begin_line,
                                   stt_pkg::E_NONE);
                    slot_v[0] = kept(stt_pkg::K_COMMENT, i_emit_ws, i_emit_cm);
                    do_idle   = 1'b1;
                end
            end
            stt_pkg::M_BLOCK, stt_pkg::M_STAR, stt_pkg::M_STAR_SLASH: begin
                logic blk;
                blk = 1'b1;
                if (sc.mode != stt_pkg::M_BLOCK) begin
                    if (b == stt_pkg::CH_SLASH) begin
                        blk = 1'b0;
                        if (dp <= DEPTH_BITS'(1)) begin
                            dp        = '0;
                            slot[0]   = mk(stt_pkg::K_COMMENT, ts, span(ts, p - 1'b1),
                                           sc.begin_line, stt_pkg::E_NONE);
                            slot_v[0] = kept(stt_pkg::K_COMMENT, i_emit_ws, i_emit_cm);
                            sc.mode   = stt_pkg::M_IDLE;
                        end else begin
                            dp      = dp - 1'b1;
                            sc.mode = stt_pkg::M_BLOCK;
                        end
                    end else if (sc.mode == stt_pkg::M_STAR_SLASH && dp < DMAX) begin
                        dp = dp + 1'b1;
                    end
                end
                if (blk) begin
                    if (b == stt_pkg::CH_STAR) begin
                        sc.mode = (sc.prev_byte == stt_pkg::CH_SLASH) ?
                                  stt_pkg::M_STAR_SLASH : stt_pkg::M_STAR;
                    end else begin
                        sc.mode = stt_pkg::M_BLOCK;
                        if (b == stt_pkg::CH_NL && sc.line_count != stt_pkg::LINE_MAX) begin
                            sc.line_count = sc.line_count + 1'b1;
                        end
                    end
                end
            end
            stt_pkg::M_SPACE: begin
                if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_NL) begin
                    if (b == stt_pkg::CH_NL && sc.line_count != stt_pkg::LINE_MAX) begin
                        sc.line_count = sc.line_count + 1'b1;
                    end
                end else begin
                    slot[0]   = mk(stt_pkg::K_SPACE, ts, span(ts, p), sc.begin_line,
                                   stt_pkg::E_NONE);
                    slot_v[0] = kept(stt_pkg::K_SPACE, i_emit_ws, i_emit_cm);
                    do_idle   = 1'b1;
                end
            end
            default: begin
                if (sc.slash_pending) begin
                    sc.slash_pending = 1'b0;
                    if (b == stt_pkg::CH_SLASH) begin
                        sc.mode       = stt_pkg::M_LINECMT;
                        ts            = p1;
                        sc.begin_line = sc.line_count;
                    end else if (b == stt_pkg::CH_STAR) begin
                        sc.mode       = stt_pkg::M_BLOCK;
                        ts            = p1;
                        sc.begin_line = sc.line_count;
                        dp            = DEPTH_BITS'(1);
                    end else begin
                        slot[0]   = mk(stt_pkg::K_OP, ts, 8'd1, sc.begin_line,
                                       stt_pkg::E_NONE);
                        slot_v[0] = 1'b1;
                        do_idle   = 1'b1;
                    end
                end else begin
                    do_idle = 1'b1;
                end
            end
        endcase

        // Second result: this byte scanned from the idle state.
        if (do_idle) begin
            sc.mode = stt_pkg::M_IDLE;
            if (is_alpha(b)) begin
                sc.mode = stt_pkg::M_IDENT;
                ts = p;
                sc.begin_line = sc.line_count;
            end else if (is_digit(b)) begin
                sc.mode = stt_pkg::M_NUMFIRST;
                ts = p;
                sc.begin_line = sc.line_count;
            end else if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_NL) begin
                sc.mode = stt_pkg::M_SPACE;
                ts = p;
                sc.begin_line = sc.line_count;
                if (b == stt_pkg::CH_NL && sc.line_count != stt_pkg::LINE_MAX) begin
                    sc.line_count = sc.line_count + 1'b1;
                end
            end else if (b == stt_pkg::CH_QUOTE) begin
                sc.mode = stt_pkg::M_STRING;
                ts = p1;
                sc.begin_line = sc.line_count;
            end else if (b == stt_pkg::CH_SLASH) begin
                ts = p;
                sc.begin_line = sc.line_count;
                sc.slash_pending = 1'b1;
            end else if (pk[5]) begin
                slot[1]   = mk(pk[4:0], p, 8'd1, sc.line_count, stt_pkg::E_NONE);
                slot_v[1] = 1'b1;
            end else if (b >= 8'd33 && b <= 8'd126) begin
                slot[1]   = mk(stt_pkg::K_NONE, p, 8'd0, sc.line_count, stt_pkg::E_CONTROL);
                slot_v[1] = 1'b1;
            end else begin
                slot[1]   = mk(stt_pkg::K_NONE, p, 8'd0, sc.line_count, stt_pkg::E_ILLEGAL);
                slot_v[1] = 1'b1;
            end
        end

        sc.prev_byte = b;

        // Third result: end of text closes whatever is still open.
        if (i_eot) begin
            len = span(ts, p1);
            unique case (sc.mode)
                stt_pkg::M_IDENT: begin
                    slot[2] = mk(stt_pkg::K_IDENT, ts, len, sc.begin_line, stt_pkg::E_NONE);
                    slot_v[2] = 1'b1;
                end
                stt_pkg::M_NUMFIRST: begin
                    slot[2] = mk(stt_pkg::K_NUM, ts, len, sc.begin_line, stt_pkg::E_NONE);
                    slot_v[2] = 1'b1;
                end
                stt_pkg::M_NUMBODY: begin
                    if (sc.digit_seen) begin
                        slot[2] = mk(stt_pkg::K_NUM, ts, len, sc.begin_line, stt_pkg::E_NONE);
                    end else begin
                        slot[2] = mk(stt_pkg::K_NONE, ts, 8'd0, sc.begin_line,
                                     stt_pkg::E_NUMBER);
                    end
                    slot_v[2] = 1'b1;
                end
                stt_pkg::M_STRING: begin
                    slot[2] = mk(stt_pkg::K_NONE, ts, 8'd0, sc.begin_line, stt_pkg::E_STRING);
                    slot_v[2] = 1'b1;
                end
                stt_pkg::M_LINECMT: begin
                    slot[2] = mk(stt_pkg::K_COMMENT, ts, len, sc.begin_line, stt_pkg::E_NONE);
                    slot_v[2] = kept(stt_pkg::K_COMMENT, i_emit_ws, i_emit_cm);
                end
                stt_pkg::M_BLOCK, stt_pkg::M_STAR, stt_pkg::M_STAR_SLASH: begin
                    slot[2] = mk(stt_pkg::K_NONE, ts, 8'd0, sc.begin_line, stt_pkg::E_COMMENT);
                    slot_v[2] = 1'b1;
                end
                stt_pkg::M_SPACE: begin
                    slot[2] = mk(stt_pkg::K_SPACE, ts, len, sc.begin_line, stt_pkg::E_NONE);
                    slot_v[2] = kept(stt_pkg::K_SPACE, i_emit_ws, i_emit_cm);
                end
                default: begin
                    if (sc.slash_pending) begin
                        slot[2] = mk(stt_pkg::K_OP, ts, 8'd1, sc.begin_line, stt_pkg::E_NONE);
                        slot_v[2] = 1'b1;
                    end
                end
            endcase
            sc = stt_pkg::scan_reset();
            ts = '0;
            p  = '0;
            dp = '0;
        end else begin
            p = p1;
        end

        o_scan   = sc;
        o_tstart = ts;
        o_pos    = p;
        o_depth  = dp;
    end

    // Pack the valid results to the front and mark the final one.
    always_comb begin
        logic [1:0] n;
        n = 2'd0;
        for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
            o_ent[i] = '0;
        end
        for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
            if (slot_v[i]) begin
                o_ent[n].res = slot[i];
                n = n + 1'b1;
            end
        end
        for (int i = 0; i < stt_pkg::MAX_RESULTS; i++) begin
            o_ent[i].last = (2'(i) == n - 1'b1) && (n != 2'd0);
        end
        o_count = n;
    end

endmodule

/* rtl/source_text_tokenizer.sv */
// The results of a byte are written into the output queue at the edge that accepts the byte.
// Throughput: one byte per cycle while each byte yields at most one result and the sink
// is ready; after a byte with two or three results, input waits until at most one is queued.
// Reset: synchronous, active low; clears scanner state, output queue and both config bits.
// After each end-of-text byte the scanner state returns to its reset value by itself.
module source_text_tokenizer #(
    parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH_BITS  = stt_pkg::DEPTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tlast,   // end_of_text
    // Token stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] token_kind, [28:5] token_offset, [36:29] token_length,
    // [60:37] line_number, [63:61] error_code
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last_of_run
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data
);

    // The scanner state below is updated in the same cycle a byte request is
    // accepted, so the next byte can follow immediately. The results of one
    // byte (at most three) are written into a four-entry queue, which drains
    // one token per cycle while the sink is ready. A byte is taken only while
    // at least three entries are free in r_count, so bursts never overflow.

    localparam int PTR_BITS = $clog2(stt_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(stt_pkg::QUEUE_DEPTH + 1);

    logic                   r_emit_ws;
    logic                   r_emit_cm;
    stt_pkg::t_scan         r_scan;
    logic [OFFSET_BITS-1:0] r_tstart;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [DEPTH_BITS-1:0]  r_depth;

    stt_pkg::t_scan         n_scan;
    logic [OFFSET_BITS-1:0] n_tstart;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [DEPTH_BITS-1:0]  n_depth;

    stt_pkg::t_entry        step_ent [stt_pkg::MAX_RESULTS];
    logic [1:0]             step_cnt;

    stt_pkg::t_entry        r_queue [stt_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    r_wr;
    logic [PTR_BITS-1:0]    r_rd;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    n_count;

    logic in_fire;
    logic out_fire;
    logic [1:0] push_n;

    stt_step #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_step (
        .i_scan    (r_scan),
        .i_tstart  (r_tstart),
        .i_pos     (r_pos),
        .i_depth   (r_depth),
        .i_byte    (s_axis_tdata),
        .i_eot     (s_axis_tlast),
        .i_emit_ws (r_emit_ws),
        .i_emit_cm (r_emit_cm),
        .o_scan    (n_scan),
        .o_tstart  (n_tstart),
        .o_pos     (n_pos),
        .o_depth   (n_depth),
        .o_ent     (step_ent),
        .o_count   (step_cnt)
    );

    // Room for three results counting the entry that leaves this cycle is not
    // assumed; the ready decision depends on registered count only.
    assign s_axis_tready = (r_count <= CNT_BITS'(1));
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign push_n        = in_fire ? step_cnt : 2'd0;

    assign m_axis_tdata  = r_queue[r_rd].res;
    assign m_axis_tlast  = r_queue[r_rd].last;

    always_comb begin
        n_count = r_count + CNT_BITS'(push_n) - CNT_BITS'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_ws <= 1'b0;
            r_emit_cm <= 1'b0;
            r_scan    <= stt_pkg::scan_reset();
            r_tstart  <= '0;
            r_pos     <= '0;
            r_depth   <= '0;
            r_wr      <= '0;
            r_rd      <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    stt_pkg::CFG_EMIT_WS: r_emit_ws <= i_cfg_data;
                    stt_pkg::CFG_EMIT_CM: r_emit_cm <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_scan   <= n_scan;
                r_tstart <= n_tstart;
                r_pos    <= n_pos;
                r_depth  <= n_depth;
                r_wr     <= r_wr + PTR_BITS'(push_n);
            end
            if (out_fire) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < stt_pkg::MAX_RESULTS; k++) begin
            if (2'(k) < push_n) begin
                r_queue[PTR_BITS'(r_wr + PTR_BITS'(k))] <= step_ent[k];
            end
        end
    end

endmodule

/* rtl/stt_checker.sv */
`include "source_text_tokenizer_defines.svh"

module stt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A held token must not change while the sink stalls.
    `STT_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Reset empties the queue and opens the input.
    `STT_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid && s_axis_tready)

    // An empty queue always has room for a byte.
    `STT_ASSERT_IMPL(a_empty_ready, i_clk, !i_rst_n, !m_axis_tvalid, s_axis_tready)

    // A token error code never exceeds the open comment code.
    `STT_ASSERT_IMPL(a_err_range, i_clk, !i_rst_n, m_axis_tvalid, m_axis_tdata[63:61] <= 3'd5)

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* verif/tokenizer_checker.sv */
// Watches the byte and token streams, predicts every token from the accepted bytes
// and compares the tokens that come out, in order.
module tokenizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_data,
    input  logic        i_byte_last,
    input  logic        i_tok_valid,
    input  logic        i_tok_ready,
    input  logic [63:0] i_tok_data,
    input  logic        i_tok_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_tokens_seen
);

    typedef struct packed {
        logic [4:0]  kind;
        logic [23:0] offset;
        logic [7:0]  length;
        logic [23:0] line;
        logic [2:0]  err;
        logic        last;
    } t_token;

    t_token          token_queue[$];
    t_token          step_tok[3];
    int              step_cnt;

    logic            show_ws, show_cm;
    stt_pkg::t_mode  mode;
    logic [23:0]     tok_start, byte_pos, line_cnt, tok_line;
    logic [7:0]      prev_b, depth;
    stt_pkg::t_base  base;
    logic            digit_seen, slash_wait;

    assign o_pending = token_queue.size();

    task automatic clear_scan();
        mode = stt_pkg::M_IDLE;
        tok_start = '0;
        byte_pos = '0;
        line_cnt = 24'd1;
        tok_line = 24'd1;
        prev_b = '0;
        depth = '0;
        base = stt_pkg::B_DEC;
        digit_seen = 1'b0;
        slash_wait = 1'b0;
    endtask

    task automatic put(logic [4:0] kind, logic [23:0] off, logic [23:0] len,
                       logic [23:0] line, logic [2:0] err);
        if (kind == stt_pkg::K_SPACE && !show_ws) return;
        if (kind == stt_pkg::K_COMMENT && !show_cm) return;
        if (step_cnt >= stt_pkg::MAX_RESULTS) return;
        step_tok[step_cnt] = '{kind, off, len[7:0], line, err, 1'b0};
        step_cnt++;
    endtask

    function automatic logic is_letter(logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function automatic logic is_dec(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [4:0] punct_of(logic [7:0] b, output logic hit);
        hit = 1'b1;
        case (b)
            "*", "+", "-": return stt_pkg::K_OP;
            ".": return stt_pkg::K_DOT;
            ":": return stt_pkg::K_COLON;
            ";": return stt_pkg::K_SEMI;
            ",": return stt_pkg::K_COMMA;
            "=": return stt_pkg::K_EQ;
            "(": return stt_pkg::K_LPAREN;
            ")": return stt_pkg::K_RPAREN;
            "{": return stt_pkg::K_LBRACE;
            "}": return stt_pkg::K_RBRACE;
            "[": return stt_pkg::K_LBRACK;
            "]": return stt_pkg::K_RBRACK;
            default: begin
                hit = 1'b0;
                return stt_pkg::K_NONE;
            end
        endcase
    endfunction

    function automatic logic in_base(logic [7:0] b);
        case (base)
            stt_pkg::B_HEX: return is_dec(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
            stt_pkg::B_OCT: return b >= "0" && b <= "7";
            stt_pkg::B_BIN: return b == "0" || b == "1";
            default: return is_dec(b);
        endcase
    endfunction

    task automatic open_token(stt_pkg::t_mode m, logic [23:0] start);
        mode = m;
        tok_start = start;
        tok_line = line_cnt;
    endtask

    task automatic bump_line();
        if (line_cnt < stt_pkg::LINE_MAX) line_cnt++;
    endtask

    // Scanning a byte from the state between tokens.
    task automatic start_byte(logic [7:0] b, logic [23:0] pos);
        logic       hit;
        logic [4:0] k;
        mode = stt_pkg::M_IDLE;
        k = punct_of(b, hit);
        if (is_letter(b)) open_token(stt_pkg::M_IDENT, pos);
        else if (is_dec(b)) open_token(stt_pkg::M_NUMFIRST, pos);
        else if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_NL) begin
            open_token(stt_pkg::M_SPACE, pos);
            if (b == stt_pkg::CH_NL) bump_line();
        end else if (b == stt_pkg::CH_QUOTE) open_token(stt_pkg::M_STRING, pos + 24'd1);
        else if (b == stt_pkg::CH_SLASH) begin
            open_token(stt_pkg::M_IDLE, pos);
            slash_wait = 1'b1;
        end else if (hit) put(k, pos, 24'd1, line_cnt, stt_pkg::E_NONE);
        else if (b >= 8'd33 && b <= 8'd126)
            put(stt_pkg::K_NONE, pos, '0, line_cnt, stt_pkg::E_CONTROL);
        else put(stt_pkg::K_NONE, pos, '0, line_cnt, stt_pkg::E_ILLEGAL);
    endtask

    task automatic number_byte(logic [7:0] b, logic [23:0] pos);
        if (in_base(b)) begin
            digit_seen = 1'b1;
            return;
        end
        if (digit_seen) put(stt_pkg::K_NUM, tok_start, pos - tok_start, tok_line, stt_pkg::E_NONE);
        else put(stt_pkg::K_NONE, tok_start, '0, tok_line, stt_pkg::E_NUMBER);
        start_byte(b, pos);
    endtask

    task automatic comment_byte(logic [7:0] b);
        if (b == stt_pkg::CH_STAR)
            mode = (prev_b == stt_pkg::CH_SLASH) ? stt_pkg::M_STAR_SLASH : stt_pkg::M_STAR;
        else begin
            mode = stt_pkg::M_BLOCK;
            if (b == stt_pkg::CH_NL) bump_line();
        end
    endtask

    task automatic scan_byte(logic [7:0] b, logic eot);
        logic [23:0] pos, len;
        pos = byte_pos;
        step_cnt = 0;
        case (mode)
            stt_pkg::M_IDENT: begin
                if (!is_letter(b) && !is_dec(b)) begin
                    put(stt_pkg::K_IDENT, tok_start, pos - tok_start, tok_line, stt_pkg::E_NONE);
                    start_byte(b, pos);
                end
            end
            stt_pkg::M_NUMFIRST: begin
                mode = stt_pkg::M_NUMBODY;
                digit_seen = 1'b0;
                if (prev_b == stt_pkg::CH_ZERO
                    && (b == stt_pkg::CH_X || b == stt_pkg::CH_O || b == stt_pkg::CH_B))
                    base = (b == stt_pkg::CH_X) ? stt_pkg::B_HEX :
                           (b == stt_pkg::CH_O) ? stt_pkg::B_OCT : stt_pkg::B_BIN;
                else if (b == stt_pkg::CH_DOT) base = stt_pkg::B_DEC;
                else begin
                    base = stt_pkg::B_DEC;
                    digit_seen = 1'b1;
                    number_byte(b, pos);
                end
            end
            stt_pkg::M_NUMBODY: number_byte(b, pos);
            stt_pkg::M_STRING: begin
                if (b == stt_pkg::CH_QUOTE && prev_b != stt_pkg::CH_BSLASH) begin
                    put(stt_pkg::K_STR, tok_start, pos - tok_start, tok_line, stt_pkg::E_NONE);
                    mode = stt_pkg::M_IDLE;
                end else if (b == stt_pkg::CH_NL) bump_line();
            end
            stt_pkg::M_LINECMT: begin
                if (b == stt_pkg::CH_NL) begin
                    put(stt_pkg::K_COMMENT, tok_start, pos - tok_start, tok_line,
                        stt_pkg::E_NONE);
                    start_byte(b, pos);
                end
            end
            stt_pkg::M_BLOCK: comment_byte(b);
            stt_pkg::M_STAR, stt_pkg::M_STAR_SLASH: begin
                if (b == stt_pkg::CH_SLASH) begin
                    if (depth <= 8'd1) begin
                        depth = '0;
                        put(stt_pkg::K_COMMENT, tok_start, pos - 24'd1 - tok_start, tok_line,
                            stt_pkg::E_NONE);
                        mode = stt_pkg::M_IDLE;
                    end else begin
                        depth--;
                        mode = stt_pkg::M_BLOCK;
                    end
                end else begin
                    if (mode == stt_pkg::M_STAR_SLASH && depth != 8'hFF) depth++;
                    comment_byte(b);
                end
            end
            stt_pkg::M_SPACE: begin
                if (b == stt_pkg::CH_SPACE || b == stt_pkg::CH_NL) begin
                    if (b == stt_pkg::CH_NL) bump_line();
                end else begin
                    put(stt_pkg::K_SPACE, tok_start, pos - tok_start, tok_line, stt_pkg::E_NONE);
                    start_byte(b, pos);
                end
            end
            default: begin
                if (slash_wait) begin
                    slash_wait = 1'b0;
                    if (b == stt_pkg::CH_SLASH) open_token(stt_pkg::M_LINECMT, pos + 24'd1);
                    else if (b == stt_pkg::CH_STAR) begin
                        open_token(stt_pkg::M_BLOCK, pos + 24'd1);
                        depth = 8'd1;
                    end else begin
                        put(stt_pkg::K_OP, tok_start, 24'd1, tok_line, stt_pkg::E_NONE);
                        start_byte(b, pos);
                    end
                end else start_byte(b, pos);
            end
        endcase
        prev_b = b;

        if (eot) begin
            // The text ends here: whatever is open gets closed or flagged.
            len = pos + 24'd1 - tok_start;
            case (mode)
                stt_pkg::M_IDENT: put(stt_pkg::K_IDENT, tok_start, len, tok_line, stt_pkg::E_NONE);
                stt_pkg::M_NUMFIRST: put(stt_pkg::K_NUM, tok_start, len, tok_line, stt_pkg::E_NONE);
                stt_pkg::M_NUMBODY: begin
                    if (digit_seen) put(stt_pkg::K_NUM, tok_start, len, tok_line, stt_pkg::E_NONE);
                    else put(stt_pkg::K_NONE, tok_start, '0, tok_line, stt_pkg::E_NUMBER);
                end
                stt_pkg::M_STRING: put(stt_pkg::K_NONE, tok_start, '0, tok_line, stt_pkg::E_STRING);
                stt_pkg::M_LINECMT:
                    put(stt_pkg::K_COMMENT, tok_start, len, tok_line, stt_pkg::E_NONE);
                stt_pkg::M_BLOCK, stt_pkg::M_STAR, stt_pkg::M_STAR_SLASH:
                    put(stt_pkg::K_NONE, tok_start, '0, tok_line, stt_pkg::E_COMMENT);
                stt_pkg::M_SPACE: put(stt_pkg::K_SPACE, tok_start, len, tok_line, stt_pkg::E_NONE);
                default: if (slash_wait)
                    put(stt_pkg::K_OP, tok_start, 24'd1, tok_line, stt_pkg::E_NONE);
            endcase
            clear_scan();
        end else begin
            byte_pos = pos + 24'd1;
        end

        for (int i = 0; i < step_cnt; i++) begin
            if (i == step_cnt - 1) step_tok[i].last = 1'b1;
            token_queue.push_back(step_tok[i]);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_token(logic [63:0] d, logic l);
        t_token w;
        if (token_queue.size() == 0) begin
            $display("MISMATCH at %0t: token with nothing predicted, data %h",
                     $realtime, d);
            o_fail_count++;
            return;
        end
        w = token_queue.pop_front();
        if (d[4:0] != w.kind) report("kind", 32'(d[4:0]), 32'(w.kind));
        if (d[28:5] != w.offset) report("offset", 32'(d[28:5]), 32'(w.offset));
        if (d[36:29] != w.length) report("length", 32'(d[36:29]), 32'(w.length));
        if (d[60:37] != w.line) report("line", 32'(d[60:37]), 32'(w.line));
        if (d[63:61] != w.err) report("error code", 32'(d[63:61]), 32'(w.err));
        if (l != w.last) report("last flag", 32'(l), 32'(w.last));
    endtask

    initial begin
        o_fail_count = 0;
        o_tokens_seen = 0;
        show_ws = 1'b0;
        show_cm = 1'b0;
        clear_scan();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            show_ws = 1'b0;
            show_cm = 1'b0;
            clear_scan();
            token_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == stt_pkg::CFG_EMIT_WS) show_ws = i_cfg_data;
                else show_cm = i_cfg_data;
            end
            if (i_byte_valid && i_byte_ready) scan_byte(i_byte_data, i_byte_last);
            if (i_tok_valid && i_tok_ready) begin
                check_token(i_tok_data, i_tok_last);
                o_tokens_seen++;
            end
        end
    end

    final begin
        if (token_queue.size() != 0) $display("%0d tokens never arrived", token_queue.size());
    end

endmodule

/* verif/tb_top.sv */
// Top of the tokenizer bench. It writes the two emit flags, streams source text
// into the block under four idling regimes, and gives the verdict. Token checking
// lives in tokenizer_checker.
module tb_top;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we, i_cfg_idx, i_cfg_data;

    int fail_count, pending, tokens_seen;
    int sender_idle_pct, receiver_stall_pct;
    int bytes_sent, quiet_cycles, leftover;

    // Bytes of the text waiting to be sent; bit 8 marks the end of a text.
    logic [8:0] text_q[$];

    source_text_tokenizer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    tokenizer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_byte_valid(s_axis_tvalid), .i_byte_ready(s_axis_tready),
        .i_byte_data(s_axis_tdata), .i_byte_last(s_axis_tlast),
        .i_tok_valid(m_axis_tvalid), .i_tok_ready(m_axis_tready),
        .i_tok_data(m_axis_tdata), .i_tok_last(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_tokens_seen(tokens_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver decides afresh on every falling edge whether to take a token.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Any stretch without a request or a token moving on either side counts toward
    // the watchdog; a hung block ends the run here.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d tokens outstanding", pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_text(string s, logic close_text);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back({close_text && (i == s.len() - 1), s[i]});
    endtask

    task automatic add_byte(logic [7:0] b);
        text_q.push_back({1'b0, b});
    endtask

    // One random token-like snippet. Most are well formed so that the scanner goes
    // deep into numbers, strings and nested comments; a few are raw noise or broken.
    task automatic add_snippet();
        string letters, hexd, puncts;
        int n;
        letters = "abcxyzABQZ_ob";
        hexd = "0123456789abcdefABCDEFg";
        puncts = "*+-.:;,=(){}[]/";
        case ($urandom_range(11))
            0: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) add_byte(letters[$urandom_range(12)]);
                if ($urandom_range(1)) add_byte(8'("0" + $urandom_range(9)));
            end
            1: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(9)));
            end
            2: begin
                // Prefixed number; the digits sometimes fall outside the base.
                add_byte(stt_pkg::CH_ZERO);
                case ($urandom_range(2))
                    0: add_byte(stt_pkg::CH_X);
                    1: add_byte(stt_pkg::CH_O);
                    default: add_byte(stt_pkg::CH_B);
                endcase
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) add_byte(hexd[$urandom_range(22)]);
            end
            3: begin
                add_byte(8'("0" + $urandom_range(9)));
                add_byte(stt_pkg::CH_DOT);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) add_byte(8'("0" + $urandom_range(9)));
            end
            4: begin
                add_byte(stt_pkg::CH_QUOTE);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(5))
                        0: begin
                            add_byte(stt_pkg::CH_BSLASH);
                            add_byte(stt_pkg::CH_QUOTE);
                        end
                        1: add_byte(stt_pkg::CH_NL);
                        default: add_byte(letters[$urandom_range(12)]);
                    endcase
                end
                add_byte(stt_pkg::CH_QUOTE);
            end
            5: begin
                add_text("/*", 1'b0);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(4))
                        0: add_text("/*q", 1'b0);
                        1: add_text("*/", 1'b0);
                        2: add_byte(stt_pkg::CH_NL);
                        3: add_byte(stt_pkg::CH_STAR);
                        default: add_byte(letters[$urandom_range(12)]);
                    endcase
                end
                add_text("*/", 1'b0);
            end
            6: begin
                add_text("//", 1'b0);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) add_byte(letters[$urandom_range(12)]);
                add_byte(stt_pkg::CH_NL);
            end
            7: begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_byte($urandom_range(1) ? stt_pkg::CH_SPACE : stt_pkg::CH_NL);
            end
            8, 9: add_byte(puncts[$urandom_range(14)]);
            default: add_byte(8'($urandom_range(255)));
        endcase
    endtask

    // Sends the queued text one request at a time. The valid line is only lowered
    // when an idle cycle is actually taken, so it never toggles twice in one step.
    task automatic send_text();
        logic [8:0] item;
        while (text_q.size() > 0) begin
            item = text_q.pop_front();
            if ($urandom_range(99) < 4) item[8] = 1'b1;
            while ($urandom_range(99) < sender_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= item[7:0];
            s_axis_tlast <= item[8];
            do @(posedge i_clk); while (!s_axis_tready);
            bytes_sent++;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits for the block to drain, and on past it, because a byte that
    // makes no token may still be in flight when the last token has come.
    task automatic drain();
        while (pending > 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_flags(logic ws, logic cm);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= stt_pkg::CFG_EMIT_WS;
        i_cfg_data <= ws;
        @(negedge i_clk);
        i_cfg_idx <= stt_pkg::CFG_EMIT_CM;
        i_cfg_data <= cm;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int idle_pct, int stall_pct, logic ws, logic cm, int n_bytes);
        drain();
        write_flags(ws, cm);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (text_q.size() < n_bytes) add_snippet();
        // Close the phase with a clean end of text so it starts fresh next time.
        add_text(";", 1'b1);
        send_text();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = stt_pkg::CFG_EMIT_WS;
        i_cfg_data = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        bytes_sent = 0;
        quiet_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed text with both flags on: every token kind, escaped quote, nested
        // comment, all prefixes, digit-dot, illegal bytes, and a bad number.
        write_flags(1'b1, 1'b1);
        add_text("a_9 0x1F 0o7 0b2 5.x \"q\\\"\" /*/*c*/*/ //d\n;:,=(){}[].+-*/~", 1'b0);
        add_byte(8'h09);
        add_byte(8'hFF);
        add_byte(8'h7F);
        add_byte(8'h00);
        add_byte(8'h80);
        add_text(" 7", 1'b1);
        // Texts cut short: open string, open comment, lone slash, number prefix.
        add_text("\"ab", 1'b1);
        add_text("/*x", 1'b1);
        add_text("/", 1'b1);
        add_text("0x", 1'b1);
        send_text();

        random_phase(0, 0, 1'b0, 1'b0, 50);
        random_phase(80, 0, 1'b1, 1'b1, 50);
        random_phase(0, 80, 1'b1, 1'b0, 50);
        random_phase(12, 12, 1'b0, 1'b1, 50);

        leftover = 0;
        while (pending > 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        leftover = pending;

        $display("Scanned %0d source bytes over four idling regimes and all emit settings;",
                 bytes_sent);
        $display("%0d tokens checked, %0d mismatches.", tokens_seen, fail_count);
        if (fail_count == 0 && leftover == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
